// ===== rtl/teq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// teq_pkg
// Shared widths, coefficients, register codes and saturation helpers for the
// three-band tone equalizer.
// ----------------------------------------------------------------------------
package teq_pkg;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 43;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int STATE_W = 48;   // band state, units of 2^-39
  localparam int BAND_W  = 43;   // band value fed to the gain stage
  localparam int TGT_W   = 50;   // filter target
  localparam int DIFF_W  = 51;   // target minus state
  localparam int ACC_W   = 61;   // sum of three band products
  localparam int MC_W    = 26;   // rounded magnitude in units of 2^28
  localparam int QE_W    = 24;   // quotient estimate for divide by five
  localparam int KNOB_W  = 13;

  // Q0.24 filter coefficients
  localparam logic signed [MUL_B_W-1:0] COEF_LOW  = 25'sd16777;
  localparam logic signed [MUL_B_W-1:0] COEF_MID  = 25'sd167772;
  localparam logic signed [MUL_B_W-1:0] COEF_HIGH = 25'sd1677722;

  // floor(2^26 / 5): estimate is low by at most one for inputs below 2^26
  localparam logic signed [MUL_B_W-1:0] RECIP5 = 25'sd13421772;

  // Half of the output divisor 20480 * 2^16 = 5 * 2^28
  localparam logic [ACC_W-1:0] ROUND_HALF = 61'd671088640;

  localparam logic [KNOB_W-1:0] KNOB_MAX   = 13'd4096;
  localparam logic [KNOB_W-1:0] KNOB_RESET = 13'd2048;

  typedef enum logic [1:0] {
    REG_BASS   = 2'd0,
    REG_MID    = 2'd1,
    REG_TREBLE = 2'd2,
    REG_COUNT  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    BAND_LOW  = 2'd0,
    BAND_HIGH = 2'd1,
    BAND_MID  = 2'd2
  } band_t;

  function automatic logic signed [BAND_W-1:0] sat43(input logic signed [DIFF_W-1:0] v);
    if (v[DIFF_W-1:BAND_W-1] == {(DIFF_W-BAND_W+1){v[BAND_W-1]}}) begin
      return v[BAND_W-1:0];
    end else if (v[DIFF_W-1]) begin
      return {1'b1, {(BAND_W-1){1'b0}}};
    end else begin
      return {1'b0, {(BAND_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [STATE_W-1:0] sat48(input logic signed [STATE_W:0] v);
    if (v[STATE_W] == v[STATE_W-1]) begin
      return v[STATE_W-1:0];
    end else if (v[STATE_W]) begin
      return {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_W-1){1'b1}}};
    end
  endfunction

  // 4096 + 8 * knob, as a multiplier operand
  function automatic logic signed [MUL_B_W-1:0] gain_of(input logic [KNOB_W-1:0] knob);
    return MUL_B_W'({knob, 3'b000}) + MUL_B_W'(4096);
  endfunction

endpackage : teq_pkg
`default_nettype wire

// ===== rtl/teq_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// teq_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module teq_mul
  import teq_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic signed [MUL_A_W-1:0]  a,
  input  wire logic signed [MUL_B_W-1:0]  b,
  output logic signed [PROD_W-1:0]        prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule : teq_mul
`default_nettype wire

// ===== rtl/three_band_tone_equalizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequence: once the input beat is taken, the sequencer runs DIFF, PMUL and
//   PUPD for each band, then GAIN per band, GSUM, ROUND, RMUL, DIV and OUT;
//   out_valid rises when OUT finds the output register free. No new sample is
//   taken meanwhile; one multiplier serves three updates, three gains, a divide.
// Reset (rst, synchronous): knobs to 2048, channel count to 2, all band states
//   and the channel counter to zero, output register empty.
// ----------------------------------------------------------------------------
// three_band_tone_equalizer
// Splits each interleaved sample into low, high and mid bands with one-pole
// filters per channel, weights each band by a knob gain and sums with
// rounding and saturation to 24 bits.
// ----------------------------------------------------------------------------
module three_band_tone_equalizer
  import teq_pkg::*;
#(
  parameter int MAX_CHANNELS = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // sample input
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [23:0] sample_in,
  input  wire logic               end_of_block,
  // result output
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      sample_out,
  output logic                    channel,
  output logic                    block_end,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W0 = $clog2(MAX_CHANNELS + 1);
  localparam int CNT_W  = (CNT_W0 < 2) ? 2 : CNT_W0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,    // d = sat(target - state)
    S_PMUL,    // d * coefficient
    S_PUPD,    // state += rounded product
    S_GAIN,    // band * gain, accumulate previous product
    S_GSUM,    // accumulate last product
    S_ROUND,   // |acc| + half divisor, drop 28 bits
    S_RMUL,    // multiply by reciprocal of five
    S_DIV,     // quotient estimate and remainder
    S_OUT      // correct, saturate, load output register
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [KNOB_W-1:0] bass_knob;
  logic [KNOB_W-1:0] mid_knob;
  logic [KNOB_W-1:0] treble_knob;
  logic [1:0]        channel_count;
  logic [KNOB_W-1:0] knob_wr;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Clamp knob writes to full scale
  always_comb begin
    knob_wr = pwdata[KNOB_W-1:0];
    if (knob_wr > KNOB_MAX) begin
      knob_wr = KNOB_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bass_knob     <= KNOB_RESET;
      mid_knob      <= KNOB_RESET;
      treble_knob   <= KNOB_RESET;
      channel_count <= 2'd2;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_BASS:   bass_knob     <= knob_wr;
        REG_MID:    mid_knob      <= knob_wr;
        REG_TREBLE: treble_knob   <= knob_wr;
        REG_COUNT:  channel_count <= pwdata[1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_BASS:   prdata = 32'(bass_knob);
      REG_MID:    prdata = 32'(mid_knob);
      REG_TREBLE: prdata = 32'(treble_knob);
      REG_COUNT:  prdata = 32'(channel_count);
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  state_t                    state;
  band_t                     bidx;       // band being filtered or weighted
  logic [CH_W-1:0]           ch;         // channel of the sample in flight
  logic [CH_W-1:0]           next_channel;
  logic                      eob;
  logic signed [TGT_W-1:0]   tgt;
  logic signed [BAND_W-1:0]  opa;
  logic signed [STATE_W-1:0] band_state [3][MAX_CHANNELS];
  logic signed [BAND_W-1:0]  band_q [3];
  logic signed [ACC_W-1:0]   acc;
  logic                      neg;
  logic                      big;
  logic [MC_W-1:0]           mc;
  logic [QE_W-1:0]           qe;
  logic [3:0]                rem;

  // Shared multiplier
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  teq_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // --------------------------------------------------------------------------
  // Combinational datapath
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]          cnt_eff;
  logic [CH_W-1:0]           ch_sel;
  logic [CH_W-1:0]           ch_after;
  logic signed [STATE_W-1:0] s_cur;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  rnd_sum;
  logic signed [PROD_W-25:0] rnd;
  logic signed [STATE_W:0]   s_sum;
  logic signed [STATE_W-1:0] s_new;
  logic signed [DIFF_W-1:0]  tgt_sub;
  logic signed [MUL_B_W-1:0] coef;
  logic signed [MUL_B_W-1:0] gain;
  logic [ACC_W-1:0]          mag_r;
  logic [QE_W-1:0]           qe_w;
  logic [MC_W:0]             rem_w;
  logic [QE_W:0]             q;
  logic signed [23:0]        y;
  logic                      out_load;

  // Effective channel count: zero acts as one, clamp at the channel limit
  always_comb begin
    if (channel_count == 2'd0) begin
      cnt_eff = CNT_W'(1);
    end else if (CNT_W'(channel_count) > CNT_W'(MAX_CHANNELS)) begin
      cnt_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      cnt_eff = CNT_W'(channel_count);
    end
  end

  always_comb begin
    // Counter left beyond a reduced count falls back to channel zero
    ch_sel = (CNT_W'(next_channel) >= cnt_eff) ? '0 : next_channel;
    if (end_of_block || (CNT_W'(ch_sel) + CNT_W'(1) >= cnt_eff)) begin
      ch_after = '0;
    end else begin
      ch_after = CH_W'(CNT_W'(ch_sel) + CNT_W'(1));
    end
  end

  always_comb begin
    unique case (bidx)
      BAND_LOW:  begin coef = COEF_LOW;  gain = gain_of(bass_knob);   end
      BAND_HIGH: begin coef = COEF_HIGH; gain = gain_of(treble_knob); end
      BAND_MID:  begin coef = COEF_MID;  gain = gain_of(mid_knob);    end
      default:   begin coef = '0;        gain = '0;                   end
    endcase
  end

  always_comb begin
    s_cur   = band_state[bidx][ch];
    diff    = DIFF_W'(tgt) - DIFF_W'(s_cur);
    // floor((p + 2^23) / 2^24)
    rnd_sum = prod + PROD_W'(64'sd8388608);
    rnd     = rnd_sum[PROD_W-1:24];
    s_sum   = (STATE_W+1)'(s_cur) + (STATE_W+1)'(rnd);
    s_new   = sat48(s_sum);
    tgt_sub = DIFF_W'(tgt) - DIFF_W'(s_new);

    // |acc| + half divisor in one add: -acc + C = ~acc + (C + 1)
    if (acc[ACC_W-1]) begin
      mag_r = ~acc + ROUND_HALF + ACC_W'(1);
    end else begin
      mag_r = acc + ROUND_HALF;
    end

    qe_w  = prod[MC_W+QE_W-1:MC_W];
    rem_w = (MC_W+1)'(mc) - ((MC_W+1)'({qe_w, 2'b00}) + (MC_W+1)'(qe_w));

    q = (QE_W+1)'(qe) + (QE_W+1)'(rem >= 4'd5);
    if (neg) begin
      if (big || q > (QE_W+1)'(8388608)) begin
        y = 24'sh800000;
      end else begin
        y = 24'(~q + (QE_W+1)'(1));
      end
    end else begin
      if (big || q > (QE_W+1)'(8388607)) begin
        y = 24'sh7fffff;
      end else begin
        y = 24'(q);
      end
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = opa;
    mul_b  = coef;
    unique case (state)
      S_PMUL: begin
        mul_en = 1'b1;
      end
      S_GAIN: begin
        mul_en = 1'b1;
        mul_a  = band_q[bidx];
        mul_b  = gain;
      end
      S_RMUL: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(mc);
        mul_b  = RECIP5;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Take a new sample only between items and outside reset
  assign in_stall = rst || (state != S_IDLE);

  // Load the output register when the result is ready and the register is free
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bidx         <= BAND_LOW;
      ch           <= '0;
      next_channel <= '0;
      out_valid    <= 1'b0;
      for (int b = 0; b < 3; b++) begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
          band_state[b][c] <= '0;
        end
      end
    end else begin
      // Raise valid on a new result, drop it once the consumer takes the beat
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            // Sample enters as x * 2^16, sign carried into the upper bits
            tgt          <= TGT_W'($signed({sample_in, 16'h0000}));
            eob          <= end_of_block;
            ch           <= ch_sel;
            next_channel <= ch_after;
            bidx         <= BAND_LOW;
            state        <= S_DIFF;
          end
        end

        S_DIFF: begin
          opa   <= sat43(diff);
          state <= S_PMUL;
        end

        S_PMUL: begin
          state <= S_PUPD;
        end

        S_PUPD: begin
          band_state[bidx][ch] <= s_new;
          band_q[bidx]         <= sat43(DIFF_W'(s_new));
          // Next band follows what this band leaves behind
          tgt                  <= TGT_W'(tgt_sub);
          unique case (bidx)
            BAND_LOW: begin
              bidx  <= BAND_HIGH;
              state <= S_DIFF;
            end
            BAND_HIGH: begin
              bidx  <= BAND_MID;
              state <= S_DIFF;
            end
            default: begin
              bidx  <= BAND_LOW;
              state <= S_GAIN;
            end
          endcase
        end

        S_GAIN: begin
          // Product of the previous band lands now; clear on the first band
          if (bidx == BAND_LOW) begin
            acc <= '0;
          end else begin
            acc <= acc + ACC_W'(prod);
          end
          unique case (bidx)
            BAND_LOW:  bidx <= BAND_HIGH;
            BAND_HIGH: bidx <= BAND_MID;
            default: begin
              bidx  <= BAND_LOW;
              state <= S_GSUM;
            end
          endcase
        end

        S_GSUM: begin
          acc   <= acc + ACC_W'(prod);
          state <= S_ROUND;
        end

        S_ROUND: begin
          neg   <= acc[ACC_W-1];
          // At or above 2^26 the quotient is far past 24-bit range
          big   <= |mag_r[ACC_W-1:MC_W+28];
          mc    <= mag_r[MC_W+27:28];
          state <= S_RMUL;
        end

        S_RMUL: begin
          state <= S_DIV;
        end

        S_DIV: begin
          // Estimate is exact or one low; remainder tells which
          qe    <= qe_w;
          rem   <= rem_w[3:0];
          state <= S_OUT;
        end

        S_OUT: begin
          // Hold until the output register is free
          if (out_load) begin
            sample_out <= y;
            channel    <= ch[0];
            block_end  <= eob;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule : three_band_tone_equalizer
`default_nettype wire
